// File: rtl/core/lock_manager_deadlock_detect_macros.svh
// Assertion macros for the lock manager with deadlock detection.
// Needs clk and rst_n in the scope that uses them.
`ifndef LOCK_MANAGER_DEADLOCK_DETECT_MACROS_SVH
`define LOCK_MANAGER_DEADLOCK_DETECT_MACROS_SVH

// same-cycle implication
`define LDD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lock manager assertion failed");

// next-cycle implication
`define LDD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lock manager assertion failed");

`endif

// File: rtl/core/ldd_pkg.sv
// Shared types and constants of the lock manager.
// No dependencies.
package ldd_pkg;

  localparam int PID_W   = 6;
  localparam int LID_W   = 4;
  localparam int CFG_W   = 5;
  localparam int CAP     = 16;
  localparam int CNT_W   = 5;

  localparam logic [1:0] FN_LOCK   = 2'd0;
  localparam logic [1:0] FN_TRY    = 2'd1;
  localparam logic [1:0] FN_UNLOCK = 2'd2;

  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0,
    ST_PARKED  = 3'd1,
    ST_TRYFAIL = 3'd2,
    ST_FREED   = 3'd3,
    ST_HANDED  = 3'd4,
    ST_REJECT  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOCK,
    S_UNL,
    S_LINK,
    S_WOWN,
    S_WWAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [PID_W-1:0] owner;
    logic             held;
    logic [PID_W-1:0] head;
    logic [PID_W-1:0] tail;
  } lock_ent_t;

  typedef struct packed {
    logic             clr;
    logic             ins;
    logic             shift;
    logic [PID_W-1:0] pid;
  } sort_ctl_t;

endpackage

// File: rtl/core/ldd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ldd_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/ldd_sorter.sv
// Sorted list of cycle members: insertion on append, shift out from the head.
// Depends on ldd_pkg.
module ldd_sorter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ldd_pkg::sort_ctl_t          ctl,
  output logic [ldd_pkg::PID_W-1:0]   head,
  output logic [ldd_pkg::CNT_W-1:0]   cnt
);
  import ldd_pkg::*;

  logic [PID_W-1:0] mem_r [CAP];
  logic [PID_W-1:0] ins_v [CAP];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CAP-1:0]   gt;

  // entries above the new pid move up one place
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      gt[i] = (CNT_W'(i) < cnt_r) && (mem_r[i] > ctl.pid);
    end
    for (int i = 0; i < CAP; i++) begin
      if (i > 0 && gt[(i > 0) ? i - 1 : 0]) ins_v[i] = mem_r[(i > 0) ? i - 1 : 0];
      else if (gt[i] || CNT_W'(i) == cnt_r) ins_v[i] = ctl.pid;
      else ins_v[i] = mem_r[i];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.clr) cnt_nxt = '0;
    else if (ctl.ins) cnt_nxt = cnt_r + CNT_W'(1);
    else if (ctl.shift) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      for (int i = 0; i < CAP; i++) mem_r[i] <= ins_v[i];
    end else if (ctl.shift) begin
      for (int i = 0; i < CAP - 1; i++) mem_r[i] <= mem_r[i + 1];
    end
  end

  assign head = mem_r[0];
  assign cnt  = cnt_r;

endmodule

// File: rtl/core/lock_manager_deadlock_detect.sv
// Top level of the lock manager with wait-for deadlock detection.
// Depends on ldd_pkg, ldd_ram, ldd_sorter and the macros header.
//
// One request is taken when start is high and busy is low. Input rejects
// answer in the cycle after; grant, trylock fail, free and waiting-pid
// rejects answer after the lock table read and S_LOCK, handover after a
// waiter_next RAM read too. A park that blocks walks the chain lock -> owner
// -> lock that owner waits on, each link a lock table then a wait table RAM
// read; S_EMIT gives each cycle member its own beat. Results appear for one
// cycle each on out_valid and cannot be held off. State is valid from reset
// on: lock table and waiting flags use per-entry valid flops, no clearing pass.
`include "lock_manager_deadlock_detect_macros.svh"
module lock_manager_deadlock_detect #(
  parameter int LOCKS = 16,
  parameter int PROCS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_func,
  input  logic [ldd_pkg::PID_W-1:0]  in_pid,
  input  logic [ldd_pkg::LID_W-1:0]  in_lock_id,
  input  logic                       cfg_we,
  input  logic [ldd_pkg::CFG_W-1:0]  cfg_wdata,
  output logic                       out_valid,
  output logic [2:0]                 out_status,
  output logic [ldd_pkg::PID_W-1:0]  out_new_owner,
  output logic                       out_deadlock,
  output logic [ldd_pkg::PID_W-1:0]  out_cycle_pid,
  output logic                       out_last
);
  import ldd_pkg::*;

  localparam int LW   = $clog2(LOCKS);
  localparam int PW   = $clog2(PROCS);
  localparam int CAPL = (LOCKS < CAP) ? LOCKS : CAP;
  localparam int EW   = $bits(lock_ent_t);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] num_locks_r;
  logic [CFG_W-1:0] act;
  logic [1:0]       func_r;
  logic [PID_W-1:0] pid_r;
  logic [LW-1:0]    id_r;
  lock_ent_t        ent_r, ent_nxt;
  logic [LW-1:0]    cur_r, cur_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt;
  logic [PID_W-1:0] own_r, own_nxt;

  logic [LOCKS-1:0] lv_r;
  logic             lrd_ok_r;
  logic [PROCS-1:0] wv_r;

  // lock table RAM
  logic             l_we, l_re;
  logic [LW-1:0]    l_waddr, l_raddr;
  lock_ent_t        l_wdata, l_rdata, l_ent;
  // wait table RAM
  logic             w_we, w_re;
  logic [PW-1:0]    w_waddr, w_raddr;
  logic [LW-1:0]    w_wdata, w_rdata;
  // waiter_next RAM
  logic             n_we, n_re;
  logic [PW-1:0]    n_waddr, n_raddr;
  logic [PID_W-1:0] n_wdata, n_rdata;

  logic             wv_set, wv_clr;
  logic [PW-1:0]    wv_idx;

  sort_ctl_t        sctl;
  logic [PID_W-1:0] s_head;
  logic [CNT_W-1:0] s_cnt;

  logic             o_valid_r, o_valid_nxt;
  status_t          o_status_r, o_status_nxt;
  logic [PID_W-1:0] o_owner_r, o_owner_nxt;
  logic             o_dl_r, o_dl_nxt;
  logic [PID_W-1:0] o_cpid_r, o_cpid_nxt;
  logic             o_last_r, o_last_nxt;

  // decoded conditions
  logic accept, reject_in, pid_waiting, unl_free, tail_none, walk_stop, own_wait;
  logic [PW-1:0] pid_idx;

  ldd_ram #(.W(EW), .D(LOCKS)) u_lock_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
  );
  ldd_ram #(.W(LW), .D(PROCS)) u_wait_ram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .re(w_re), .raddr(w_raddr), .rdata(w_rdata)
  );
  ldd_ram #(.W(PID_W), .D(PROCS)) u_next_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .re(n_re), .raddr(n_raddr), .rdata(n_rdata)
  );
  ldd_sorter u_sorter (
    .clk(clk), .rst_n(rst_n), .ctl(sctl), .head(s_head), .cnt(s_cnt)
  );

  assign act = (num_locks_r > CFG_W'(CAPL)) ? CFG_W'(CAPL) : num_locks_r;
  assign busy = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign reject_in = (in_func == 2'd3) || (in_pid == '0)
                  || (9'(in_pid) >= 9'(PROCS)) || ({1'b0, in_lock_id} >= act);
  assign pid_idx = PW'(pid_r);
  assign l_ent = lrd_ok_r ? l_rdata : '0;
  assign pid_waiting = wv_r[pid_idx];
  assign unl_free = (l_ent.head == '0) || (9'(l_ent.head) >= 9'(PROCS));
  assign tail_none = (l_ent.tail == '0) || (9'(l_ent.tail) >= 9'(PROCS));
  assign walk_stop = (steps_r >= act) || (l_ent.owner == '0)
                  || (9'(l_ent.owner) >= 9'(PROCS));
  assign own_wait = wv_r[PW'(own_r)];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && !reject_in) state_nxt = S_LOCK;
      S_LOCK: begin
        if (func_r == FN_UNLOCK) state_nxt = unl_free ? S_IDLE : S_UNL;
        else if (pid_waiting || !l_ent.held || func_r == FN_TRY) state_nxt = S_IDLE;
        else state_nxt = S_LINK;
      end
      S_UNL:   state_nxt = S_IDLE;
      S_LINK:  state_nxt = S_WOWN;
      S_WOWN:  state_nxt = walk_stop ? S_IDLE : S_WWAIT;
      S_WWAIT: begin
        if (!own_wait) state_nxt = S_IDLE;
        else if (w_rdata == id_r) state_nxt = S_EMIT;
        else state_nxt = S_WOWN;
      end
      S_EMIT:  if (s_cnt == CNT_W'(1)) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory control and result beats
  always_comb begin
    l_we = 1'b0; l_waddr = id_r; l_wdata = '0;
    l_re = 1'b0; l_raddr = id_r;
    w_we = 1'b0; w_waddr = pid_idx; w_wdata = id_r;
    w_re = 1'b0; w_raddr = PW'(l_ent.owner);
    n_we = 1'b0; n_waddr = pid_idx; n_wdata = '0;
    n_re = 1'b0; n_raddr = PW'(l_ent.head);
    wv_set = 1'b0; wv_clr = 1'b0; wv_idx = pid_idx;
    sctl = '{clr: 1'b0, ins: 1'b0, shift: 1'b0, pid: l_ent.owner};
    ent_nxt = ent_r; cur_nxt = cur_r; steps_nxt = steps_r; own_nxt = own_r;
    o_valid_nxt = 1'b0; o_status_nxt = ST_GRANTED; o_owner_nxt = '0;
    o_dl_nxt = 1'b0; o_cpid_nxt = '0; o_last_nxt = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        l_raddr = LW'(in_lock_id);
        if (accept && reject_in) begin
          o_valid_nxt = 1'b1; o_status_nxt = ST_REJECT;
        end else if (accept) begin
          l_re = 1'b1;
        end
      end
      S_LOCK: begin
        ent_nxt = l_ent;
        if (func_r == FN_UNLOCK) begin
          if (unl_free) begin
            l_we = 1'b1;
            o_valid_nxt = 1'b1; o_status_nxt = ST_FREED;
          end else begin
            n_re = 1'b1;
          end
        end else if (pid_waiting) begin
          o_valid_nxt = 1'b1; o_status_nxt = ST_REJECT;
        end else if (!l_ent.held) begin
          l_we = 1'b1;
          l_wdata = '{owner: pid_r, held: 1'b1, head: l_ent.head, tail: l_ent.tail};
          o_valid_nxt = 1'b1; o_status_nxt = ST_GRANTED;
        end else if (func_r == FN_TRY) begin
          o_valid_nxt = 1'b1; o_status_nxt = ST_TRYFAIL;
        end else begin
          // park: enqueue at tail, record the lock waited on
          l_we = 1'b1;
          l_wdata = '{owner: l_ent.owner, held: 1'b1,
                      head: tail_none ? pid_r : l_ent.head, tail: pid_r};
          w_we = 1'b1;
          wv_set = 1'b1;
          n_we = 1'b1;
          ent_nxt.tail = tail_none ? '0 : l_ent.tail;
        end
      end
      S_UNL: begin
        l_we = 1'b1;
        l_wdata = '{owner: ent_r.head, held: 1'b1, head: n_rdata,
                    tail: (n_rdata == '0) ? '0 : ent_r.tail};
        wv_clr = 1'b1;
        wv_idx = PW'(ent_r.head);
        o_valid_nxt = 1'b1; o_status_nxt = ST_HANDED; o_owner_nxt = ent_r.head;
      end
      S_LINK: begin
        n_waddr = PW'(ent_r.tail);
        n_wdata = pid_r;
        n_we = (ent_r.tail != '0);
        l_re = 1'b1;
        cur_nxt = id_r;
        steps_nxt = '0;
        sctl.clr = 1'b1;
      end
      S_WOWN: begin
        if (walk_stop) begin
          o_valid_nxt = 1'b1; o_status_nxt = ST_PARKED;
        end else begin
          sctl.ins = 1'b1;
          own_nxt = l_ent.owner;
          w_re = 1'b1;
        end
      end
      S_WWAIT: begin
        if (!own_wait) begin
          o_valid_nxt = 1'b1; o_status_nxt = ST_PARKED;
        end else if (w_rdata != id_r) begin
          cur_nxt = w_rdata;
          steps_nxt = steps_r + CNT_W'(1);
          l_re = 1'b1;
          l_raddr = w_rdata;
        end
      end
      S_EMIT: begin
        sctl.shift = 1'b1;
        o_valid_nxt = 1'b1; o_status_nxt = ST_PARKED; o_dl_nxt = 1'b1;
        o_cpid_nxt = s_head; o_last_nxt = (s_cnt == CNT_W'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_locks_r <= CFG_W'(16);
      lv_r        <= '0;
      wv_r        <= '0;
      o_valid_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      o_valid_r <= o_valid_nxt;
      if (cfg_we) num_locks_r <= cfg_wdata;
      if (l_we) lv_r[l_waddr] <= 1'b1;
      if (wv_set) wv_r[wv_idx] <= 1'b1;
      else if (wv_clr) wv_r[wv_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      pid_r  <= in_pid;
      id_r   <= LW'(in_lock_id);
    end
    if (l_re) lrd_ok_r <= lv_r[l_raddr];
    ent_r      <= ent_nxt;
    cur_r      <= cur_nxt;
    steps_r    <= steps_nxt;
    own_r      <= own_nxt;
    o_status_r <= o_status_nxt;
    o_owner_r  <= o_owner_nxt;
    o_dl_r     <= o_dl_nxt;
    o_cpid_r   <= o_cpid_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid     = o_valid_r;
  assign out_status    = o_status_r;
  assign out_new_owner = o_owner_r;
  assign out_deadlock  = o_dl_r;
  assign out_cycle_pid = o_cpid_r;
  assign out_last      = o_last_r;

  `LDD_ASSERT_NOW(a_dl_parked, out_valid && out_deadlock, out_status == ST_PARKED)
  `LDD_ASSERT_NOW(a_single_last, out_valid && !out_deadlock, out_last && out_cycle_pid == '0)
  `LDD_ASSERT_NEXT(a_emit_beat, state_r == S_EMIT, out_valid && out_deadlock)
  `LDD_ASSERT_NOW(a_walk_bound, state_r == S_WWAIT, steps_r < act)

endmodule

// File: bench/tb_lock_manager_deadlock_detect.sv
// Self-checking bench for lock_manager_deadlock_detect: lock/trylock/unlock
// requests, handover order and wait-for cycle reports. Depends on ldd_pkg and lock_manager_deadlock_detect.
module tb_lock_manager_deadlock_detect;
  import ldd_pkg::*;

  localparam int NLOCK   = 16;
  localparam int NPROC   = 64;
  localparam int WNONE   = 255;
  localparam int LIMIT   = 400000;
  localparam int DRAIN   = 80;

  typedef struct packed {
    logic [1:0]       func;
    logic [PID_W-1:0] pid;
    logic [LID_W-1:0] lock_id;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [PID_W-1:0] new_owner;
    logic             deadlock;
    logic [PID_W-1:0] cycle_pid;
    logic             last;
  } resp_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_func = '0;
  logic [PID_W-1:0] in_pid = '0;
  logic [LID_W-1:0] in_lock_id = '0;
  logic cfg_we = 0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic [2:0] out_status;
  logic [PID_W-1:0] out_new_owner;
  logic out_deadlock;
  logic [PID_W-1:0] out_cycle_pid;
  logic out_last;

  lock_manager_deadlock_detect u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_pid(in_pid), .in_lock_id(in_lock_id),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_status(out_status), .out_new_owner(out_new_owner),
    .out_deadlock(out_deadlock), .out_cycle_pid(out_cycle_pid), .out_last(out_last)
  );

  always #1 clk = ~clk;

  // shadow lock table
  int unsigned lm_locks;
  int lm_owner[NLOCK];
  bit lm_held[NLOCK];
  int lm_waits[NPROC];
  int lm_next[NPROC];
  int lm_head[NLOCK];
  int lm_tail[NLOCK];

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  int errors = 0;
  int cycles = 0;
  bit traffic_on = 0;
  bit driving = 0;

  function automatic int unsigned active_locks();
    return (lm_locks > NLOCK) ? NLOCK : lm_locks;
  endfunction

  function automatic resp_t mk(status_t s, int own, bit dl, int cp, bit lst);
    resp_t r;
    r.status = s; r.new_owner = PID_W'(own); r.deadlock = dl;
    r.cycle_pid = PID_W'(cp); r.last = lst;
    return r;
  endfunction

  task automatic predict_request(req_t q);
    int id, p, cur, steps, cnt, o, w, v, j;
    int members[16];
    bit found;
    id = int'(q.lock_id);
    p = int'(q.pid);
    if (q.func > FN_UNLOCK || p == 0 || id >= active_locks()) begin
      expected_resps.push_back(mk(ST_REJECT, 0, 0, 0, 1));
      return;
    end
    if (q.func == FN_UNLOCK) begin
      o = lm_head[id];
      if (o == 0) begin
        lm_held[id] = 0; lm_owner[id] = 0; lm_head[id] = 0; lm_tail[id] = 0;
        expected_resps.push_back(mk(ST_FREED, 0, 0, 0, 1));
      end else begin
        lm_head[id] = lm_next[o];
        if (lm_head[id] == 0) lm_tail[id] = 0;
        lm_waits[o] = WNONE;
        lm_owner[id] = o;
        lm_held[id] = 1;
        expected_resps.push_back(mk(ST_HANDED, o, 0, 0, 1));
      end
      return;
    end
    if (lm_waits[p] != WNONE) begin
      expected_resps.push_back(mk(ST_REJECT, 0, 0, 0, 1));
      return;
    end
    if (!lm_held[id]) begin
      lm_held[id] = 1; lm_owner[id] = p;
      expected_resps.push_back(mk(ST_GRANTED, 0, 0, 0, 1));
      return;
    end
    if (q.func == FN_TRY) begin
      expected_resps.push_back(mk(ST_TRYFAIL, 0, 0, 0, 1));
      return;
    end
    // park, then follow lock -> owner -> awaited lock
    lm_waits[p] = id;
    lm_next[p] = 0;
    if (lm_tail[id] == 0) lm_head[id] = p;
    else lm_next[lm_tail[id]] = p;
    lm_tail[id] = p;
    cur = id; steps = 0; cnt = 0; found = 0;
    while (!found && steps < active_locks() && lm_owner[cur] != 0) begin
      o = lm_owner[cur];
      members[cnt] = o; cnt++;
      w = lm_waits[o];
      if (w == id) found = 1;
      else if (w == WNONE) steps = NLOCK;
      else begin
        cur = w; steps++;
      end
    end
    if (!found) begin
      expected_resps.push_back(mk(ST_PARKED, 0, 0, 0, 1));
      return;
    end
    for (int i = 1; i < cnt; i++) begin
      v = members[i];
      j = i - 1;
      while (j >= 0 && members[j] > v) begin
        members[j + 1] = members[j];
        j--;
      end
      members[j + 1] = v;
    end
    for (int i = 0; i < cnt; i++)
      expected_resps.push_back(mk(ST_PARKED, 0, 1, members[i], i == cnt - 1));
  endtask

  // driver: bursts and gaps, one beat per accepted edge
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n && traffic_on) begin
      if (start && busy) begin
        // hold current beat
      end else if (pending_reqs.size() == 0) begin
        start <= 0;
        driving = 0;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 0;
      end else begin
        start <= 1;
        in_func <= pending_reqs[0].func;
        in_pid <= pending_reqs[0].pid;
        in_lock_id <= pending_reqs[0].lock_id;
        driving = 1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
    end else if (!traffic_on) begin
      start <= 0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy && pending_reqs.size() > 0 && driving) begin
      predict_request(pending_reqs.pop_front());
      driving = 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    resp_t want;
    cycles++;
    if (rst_n && out_valid) begin
      if (expected_resps.size() == 0) begin
        $error("result with nothing expected: status %0d", out_status);
        errors++;
      end else begin
        want = expected_resps.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status); errors++;
        end
        if (out_new_owner !== want.new_owner) begin
          $error("new_owner: expected %0d, got %0d", want.new_owner, out_new_owner);
          errors++;
        end
        if (out_deadlock !== want.deadlock) begin
          $error("deadlock: expected %0d, got %0d", want.deadlock, out_deadlock); errors++;
        end
        if (out_cycle_pid !== want.cycle_pid) begin
          $error("cycle_pid: expected %0d, got %0d", want.cycle_pid, out_cycle_pid);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last); errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic req_t rq(logic [1:0] f, int p, int l);
    req_t r;
    r.func = f; r.pid = PID_W'(p); r.lock_id = LID_W'(l);
    return r;
  endfunction

  task automatic wait_idle();
    traffic_on = 1;
    while (pending_reqs.size() > 0 || driving || expected_resps.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_locks(int v);
    @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= CFG_W'(v);
    @(negedge clk);
    cfg_we <= 0;
    lm_locks = v;
  endtask

  // k pids each take a lock, then each asks for the next lock mod nl; with k == nl the last park closes a cycle
  task automatic queue_ring(int base_pid, int base_lock, int k, int nl);
    for (int i = 0; i < k; i++)
      pending_reqs.push_back(rq(FN_LOCK, base_pid + i, (base_lock + i) % nl));
    for (int i = 0; i < k; i++)
      pending_reqs.push_back(rq(FN_LOCK, base_pid + i, (base_lock + i + 1) % nl));
  endtask

  task automatic release_all(int nl);
    // unlocking each lock twice: each unlock hands it to the next waiter, or frees it when none waits
    for (int r = 0; r < 2; r++)
      for (int l = 0; l < nl; l++)
        pending_reqs.push_back(rq(FN_UNLOCK, 1 + $urandom_range(0, 62), l));
  endtask

  task automatic random_phase(int n, int nl);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        queue_ring($urandom_range(1, 40), $urandom_range(0, 15), $urandom_range(1, 5), 16);
        i += 4;
      end else if (pick == 2) begin
        pending_reqs.push_back(rq(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                                  $urandom_range(0, 15)));
      end else begin
        // small pid pool to get contention
        pending_reqs.push_back(rq(2'($urandom_range(0, 2)), $urandom_range(1, 12),
                                  $urandom_range(0, (nl > 0 ? nl : 1) - 1)));
      end
    end
  endtask

  initial begin
    lm_locks = 16;
    for (int i = 0; i < NLOCK; i++) begin
      lm_owner[i] = 0; lm_held[i] = 0; lm_head[i] = 0; lm_tail[i] = 0;
    end
    for (int i = 0; i < NPROC; i++) begin
      lm_waits[i] = WNONE; lm_next[i] = 0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: rejects, grant, trylock, handover, self-cycle, long ring
    pending_reqs.push_back(rq(2'd3, 5, 0));
    pending_reqs.push_back(rq(FN_LOCK, 0, 0));
    pending_reqs.push_back(rq(FN_UNLOCK, 63, 15));
    pending_reqs.push_back(rq(FN_LOCK, 63, 15));
    pending_reqs.push_back(rq(FN_TRY, 1, 15));
    pending_reqs.push_back(rq(FN_TRY, 1, 0));
    pending_reqs.push_back(rq(FN_LOCK, 2, 0));
    pending_reqs.push_back(rq(FN_LOCK, 3, 0));
    pending_reqs.push_back(rq(FN_TRY, 2, 5));
    pending_reqs.push_back(rq(FN_UNLOCK, 9, 0));
    pending_reqs.push_back(rq(FN_UNLOCK, 2, 0));
    pending_reqs.push_back(rq(FN_LOCK, 63, 15));
    pending_reqs.push_back(rq(FN_UNLOCK, 63, 15));
    pending_reqs.push_back(rq(FN_UNLOCK, 3, 0));
    pending_reqs.push_back(rq(FN_UNLOCK, 1, 0));
    wait_idle();
    queue_ring(40, 0, 16, 16);
    wait_idle();
    release_all(16);
    wait_idle();

    write_locks(0);
    random_phase(10, 1);
    wait_idle();
    write_locks(1);
    pending_reqs.push_back(rq(FN_LOCK, 7, 0));
    pending_reqs.push_back(rq(FN_LOCK, 7, 0));
    random_phase(10, 1);
    wait_idle();
    release_all(1);
    wait_idle();
    write_locks(31);
    queue_ring(20, 3, 16, 16);
    wait_idle();
    release_all(16);
    wait_idle();
    write_locks(5);
    random_phase(30, 5);
    wait_idle();
    release_all(16);
    wait_idle();
    write_locks(16);
    random_phase(40, 16);
    wait_idle();

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
